### rtl/core/lz77bp_pkg.sv
package lz77bp_pkg;

    localparam int WINDOW_DEPTH = 2048;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int DIST_W       = 11;
    localparam int CNT_W        = 4;

    localparam logic [DIST_W-1:0] PRODUCED_MAX = 11'h7FF;
    localparam logic [7:0]        SPACE_BYTE   = 8'h20;
    localparam logic [7:0]        FOLD_MASK    = 8'h80;
    localparam logic [CNT_W-1:0]  LEN_BIAS     = 4'd3;

    localparam logic [1:0] EMIT_IN    = 2'd0;
    localparam logic [1:0] EMIT_SPACE = 2'd1;
    localparam logic [1:0] EMIT_PEND  = 2'd2;
    localparam logic [1:0] EMIT_MEM   = 2'd3;

    typedef struct packed {
        logic       emit;
        logic [1:0] emit_sel;
        logic       emit_last;
        logic       load_raw;
        logic       dec_raw;
        logic       load_high;
        logic       load_pair;
        logic       load_pend;
        logic       dec_count;
        logic       mem_rd;
        logic       clear;
    } lz_cmd_t;

    typedef struct packed {
        logic is_lit;
        logic is_raw;
        logic is_space;
        logic dist_ok;
        logic raw_done;
        logic copy_done;
        logic slot_free;
        logic eor_hold;
    } lz_status_t;

endpackage

### rtl/core/lz77bp_ctrl.sv
module lz77bp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tlast,
    output logic                   s_axis_tready,
    input  lz77bp_pkg::lz_status_t stat,
    output lz77bp_pkg::lz_cmd_t    cmd
);
    import lz77bp_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SPACE2  = 2'd1;
    localparam logic [1:0] ST_COPY_RD = 2'd2;
    localparam logic [1:0] ST_COPY_WR = 2'd3;

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_RAW  = 2'd1;
    localparam logic [1:0] PH_PAIR = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_CMD;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd           = '0;
        cmd.emit_sel  = EMIT_IN;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = stat.slot_free;
                if (s_axis_tvalid && stat.slot_free)
                begin
                    case (phase_reg)
                        PH_RAW:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            cmd.dec_raw   = 1'b1;
                            if (stat.raw_done)
                                phase_next = PH_CMD;
                        end
                        PH_PAIR:
                        begin
                            phase_next    = PH_CMD;
                            cmd.load_pair = 1'b1;
                            if (stat.dist_ok)
                                state_next = ST_COPY_RD;
                        end
                        default:
                        begin
                            if (stat.is_lit)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_last = 1'b1;
                            end
                            else if (stat.is_raw)
                            begin
                                cmd.load_raw = 1'b1;
                                phase_next   = PH_RAW;
                            end
                            else if (stat.is_space)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_sel  = EMIT_SPACE;
                                cmd.load_pend = 1'b1;
                                state_next    = ST_SPACE2;
                            end
                            else
                            begin
                                cmd.load_high = 1'b1;
                                phase_next    = PH_PAIR;
                            end
                        end
                    endcase
                    if (s_axis_tlast && state_next == ST_IDLE)
                    begin
                        cmd.clear  = 1'b1;
                        phase_next = PH_CMD;
                    end
                end
            end
            ST_SPACE2:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_PEND;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = stat.eor_hold;
                    state_next    = ST_IDLE;
                end
            end
            ST_COPY_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_COPY_WR;
            end
            default:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_MEM;
                    cmd.emit_last = stat.copy_done;
                    cmd.dec_count = 1'b1;
                    if (stat.copy_done)
                    begin
                        cmd.clear  = stat.eor_hold;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_COPY_RD;
                end
            end
        endcase
    end

endmodule

### rtl/core/lz77bp_dpath.sv
module lz77bp_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
    output logic                   m_axis_tlast,
    input  lz77bp_pkg::lz_cmd_t    cmd,
    output lz77bp_pkg::lz_status_t stat
);
    import lz77bp_pkg::*;

    logic [7:0]        hist_mem [WINDOW_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [WIN_AW-1:0] wp_reg;
    logic [DIST_W-1:0] produced_reg;
    logic [CNT_W-1:0]  raw_left_reg;
    logic [7:0]        high_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [7:0]        pend_reg;
    logic              eor_hold_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic [7:0]        c;
    logic [DIST_W-1:0] pair_dist;
    logic [CNT_W-1:0]  len;
    logic [7:0]        emit_byte;
    logic [WIN_AW-1:0] rd_addr;

    assign c         = s_axis_tdata;
    assign pair_dist = {high_reg[5:0], c[7:3]};
    assign len       = {1'b0, c[2:0]} + LEN_BIAS;

    always_comb
    begin
        stat           = '0;
        stat.is_lit    = (c == 8'h00) || (c inside {[8'h09:8'h7F]});
        stat.is_raw    = c inside {[8'h01:8'h08]};
        stat.is_space  = c >= 8'hC0;
        stat.dist_ok   = (pair_dist != '0) && (pair_dist <= produced_reg);
        stat.raw_done  = raw_left_reg <= CNT_W'(1);
        stat.copy_done = count_reg == CNT_W'(1);
        stat.slot_free = !out_valid_reg || m_axis_tready;
        stat.eor_hold  = eor_hold_reg;
    end

    always_comb
    begin
        case (cmd.emit_sel)
            EMIT_IN:    emit_byte = c;
            EMIT_SPACE: emit_byte = SPACE_BYTE;
            EMIT_PEND:  emit_byte = pend_reg;
            default:    emit_byte = rd_data_reg;
        endcase
    end

    assign rd_addr = wp_reg - WIN_AW'(dist_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            hist_mem[wp_reg] <= emit_byte;
        if (cmd.mem_rd)
            rd_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_high)
            high_reg <= c;
        if (cmd.load_pair)
            dist_reg <= pair_dist;
        if (cmd.load_pend)
            pend_reg <= c ^ FOLD_MASK;
        if (cmd.emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            produced_reg  <= '0;
            raw_left_reg  <= '0;
            count_reg     <= '0;
            eor_hold_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cmd.load_raw)
                raw_left_reg <= c[CNT_W-1:0];
            else if (cmd.dec_raw && raw_left_reg != '0)
                raw_left_reg <= raw_left_reg - CNT_W'(1);
            if (cmd.load_pair)
            begin
                count_reg    <= len;
                eor_hold_reg <= s_axis_tlast;
            end
            else if (cmd.dec_count)
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.load_pend)
                eor_hold_reg <= s_axis_tlast;
            if (cmd.emit)
            begin
                wp_reg <= wp_reg + WIN_AW'(1);
                if (produced_reg != PRODUCED_MAX)
                    produced_reg <= produced_reg + DIST_W'(1);
            end
            if (cmd.clear)
            begin
                wp_reg       <= '0;
                produced_reg <= '0;
                raw_left_reg <= '0;
                eor_hold_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### rtl/core/lz77_byte_pair_decompressor_unit.sv
// PalmDoc-style LZ77 record decompressor: one compressed byte per input beat, tlast on the
// final byte of a record, one decompressed byte per output beat with tlast on the last byte
// that an input beat produces. A literal or raw-run byte is emitted directly, a space-folded
// byte emits a space and then the folded byte, the first byte of a pair is only held, and the
// second byte of a valid pair copies each byte through a registered read of the 2048-byte
// single-port history memory ahead of each history write. An output register holds one
// pending beat; while it waits on the consumer, the decoder and the input side stall with it.
// The decoder phase, history write pointer, produced count and raw-run count clear after the
// byte marked tlast; the history memory needs no clearing pass after reset.
module lz77_byte_pair_decompressor_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_record
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // last_of_run
);
    import lz77bp_pkg::*;

    lz_cmd_t    cmd;
    lz_status_t stat;

    lz77bp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lz77bp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

### dv/lz77_byte_pair_decompressor_unit_checker.sv
module lz77_byte_pair_decompressor_unit_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    output int         mismatches,
    output int         bytes_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import lz77bp_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_CMD = 2'd0,
        IN_RAW    = 2'd1,
        AWAIT_LOW = 2'd2
    } decode_phase_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    text_beat_t         text_q[$];
    logic [7:0]         history [WINDOW_DEPTH];
    logic [WIN_AW-1:0]  wr_ptr;
    logic [DIST_W-1:0]  produced;
    decode_phase_e      phase;
    logic [CNT_W-1:0]   raw_left;
    logic [7:0]         high_byte;

    function void clear_record();
        phase     = AWAIT_CMD;
        raw_left  = '0;
        high_byte = '0;
        wr_ptr    = '0;
        produced  = '0;
    endfunction

    function void put_text(input logic [7:0] b);
        text_beat_t t;
        t.data = b;
        t.last = 1'b0;
        text_q = {text_q, t};
        history[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (produced != PRODUCED_MAX)
            produced = produced + 1'b1;
    endfunction

    function void decode_byte(input logic [7:0] c, input logic eor);
        int                queued_at_start;
        logic [15:0]       pair;
        logic [DIST_W-1:0] back_dist;
        logic [WIN_AW-1:0] idx;
        int                len;
        queued_at_start = text_q.size();
        case (phase)
            IN_RAW:
            begin
                put_text(c);
                if (raw_left > 0)
                    raw_left = raw_left - 1'b1;
                if (raw_left == 0)
                    phase = AWAIT_CMD;
            end
            AWAIT_LOW:
            begin
                pair      = {high_byte, c};
                back_dist = pair[13:3];
                len       = int'(pair[2:0]) + 3;
                phase     = AWAIT_CMD;
                high_byte = '0;
                if (back_dist != 0 && back_dist <= produced)
                begin
                    for (int j = 0; j < len; j++)
                    begin
                        idx = wr_ptr - back_dist;
                        put_text(history[idx]);
                    end
                end
            end
            default:
            begin
                if (c == 8'h00 || (c >= 8'h09 && c <= 8'h7F))
                    put_text(c);
                else if (c <= 8'h08)
                begin
                    raw_left = c[CNT_W-1:0];
                    phase    = IN_RAW;
                end
                else if (c >= 8'hC0)
                begin
                    put_text(SPACE_BYTE);
                    put_text(c ^ FOLD_MASK);
                end
                else
                begin
                    high_byte = c;
                    phase     = AWAIT_LOW;
                end
            end
        endcase
        if (text_q.size() > queued_at_start)
            text_q[text_q.size()-1].last = 1'b1;
        if (eor)
            clear_record();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        text_beat_t want;
        if (!rst_n)
        begin
            clear_record();
            text_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (text_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected beat: data %h last %b",
                                 $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = text_q.pop_front();
                    if (want.data !== m_axis_tdata || want.last !== m_axis_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: beat mismatch: expected data %h last %b, ",
                                      "got data %h last %b"},
                                     $time, want.data, want.last, m_axis_tdata,
                                     m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tlast);
        end
        bytes_owed = text_q.size();
    end

endmodule

### dv/lz77_byte_pair_decompressor_unit_test.sv
module lz77_byte_pair_decompressor_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int         mismatches;
    int         bytes_owed;
    bit         calm;
    int         sent;
    int         rec_produced;
    logic [7:0] rec_q[$];

    lz77_byte_pair_decompressor_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lz77_byte_pair_decompressor_unit_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .bytes_owed    (bytes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("lz77_byte_pair_decompressor_unit regression: fail");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_q.size(); i++)
            send_byte(rec_q[i], i == rec_q.size() - 1);
        rec_q.delete();
    endtask

    function automatic void add_pair(input int dist_val, input int len);
        logic [10:0] d;
        logic [2:0]  l;
        d = 11'(dist_val);
        l = 3'(len - 3);
        rec_q = {rec_q, {2'b10, d[10:5]}};
        rec_q = {rec_q, {d[4:0], l}};
    endfunction

    // keep rec_produced as the unsaturated byte count so valid distances stay in range
    function automatic void add_token(input bit dense);
        int kind;
        int n;
        int reach;
        kind  = dense ? 5 : $urandom_range(0, 9);
        reach = (rec_produced > 2047) ? 2047 : rec_produced;
        if (kind >= 5 && kind <= 8 && rec_produced == 0)
            kind = 0;
        if (kind <= 2)
        begin
            rec_q = {rec_q,
                     ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(9, 127))};
            rec_produced += 1;
        end
        else if (kind == 3)
        begin
            rec_q = {rec_q, 8'($urandom_range(192, 255))};
            rec_produced += 2;
        end
        else if (kind == 4)
        begin
            n = $urandom_range(1, 8);
            rec_q = {rec_q, 8'(n)};
            repeat (n) rec_q = {rec_q, 8'($urandom_range(0, 255))};
            rec_produced += n;
        end
        else if (kind <= 8)
        begin
            n = dense ? 10 : $urandom_range(3, 10);
            if (!dense && $urandom_range(0, 1))
                add_pair($urandom_range(1, (reach > 16) ? 16 : reach), n);
            else
                add_pair($urandom_range(1, reach), n);
            rec_produced += n;
        end
        else
        begin
            if (reach >= 2047 || $urandom_range(0, 1))
                add_pair(0, $urandom_range(3, 10));
            else
                add_pair($urandom_range(reach + 1, 2047), $urandom_range(3, 10));
        end
    endfunction

    initial
    begin : drain
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int cut;
        calm = 1'b0;
        sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hA5, 1'b0);
        // distance 1, length 10: overlapping copy
        send_byte(8'h80, 1'b0);
        send_byte(8'h0F, 1'b0);
        // zero distance
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        // distance 2047, far beyond the record
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // raw run cut short by the end of the record
        send_byte(8'h08, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h02, 1'b1);
        // distance equal to the bytes produced, then one past them
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h28, 1'b0);
        // pair left open at the end of the record
        send_byte(8'h85, 1'b1);
        send_byte(8'h20, 1'b1);

        while (sent < 140)
        begin
            calm = ($urandom_range(0, 3) == 0);
            rec_produced = 0;
            repeat ($urandom_range(1, 12)) add_token(1'b0);
            if (rec_q.size() > 1 && $urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(1, (rec_q.size() > 3) ? 3 : rec_q.size() - 1);
                repeat (cut) void'(rec_q.pop_back());
            end
            send_record();
        end

        // one long record: copies reaching far back into the history
        calm = 1'b0;
        rec_produced = 0;
        while (rec_produced < 900)
            add_token($urandom_range(0, 3) != 0);
        send_record();

        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        wait (bytes_owed == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0)
            $display("lz77_byte_pair_decompressor_unit regression: pass");
        else
            $display("lz77_byte_pair_decompressor_unit regression: fail");
        $finish;
    end

endmodule
